>>> rtl/team_grouped_queue_defines.svh
// Assertion macros for the grouped queue RTL.
// Taken in by the top level; relies on clk and rst_n being in scope.
`ifndef TEAM_GROUPED_QUEUE_DEFINES_SVH
`define TEAM_GROUPED_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define TGQ_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TGQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tgq_pkg.sv
// Shared types and constants of the grouped queue.
// No dependencies; used by tgq_ctrl, tgq_dpath, the top level and the testbench.
`default_nettype none

package tgq_pkg;

  localparam int ELEM_W       = 10;
  localparam int TEAM_W       = 5;
  localparam int NODE_W       = 10;
  localparam int CNT_W        = 11;
  localparam int NUM_ELEMENTS = 1024;
  localparam int NUM_TEAMS    = 32;
  localparam int CAPACITY     = 1024;

  // Item kinds
  localparam logic [1:0] KIND_ASSIGN  = 2'd0;
  localparam logic [1:0] KIND_ENQUEUE = 2'd1;
  localparam logic [1:0] KIND_DEQUEUE = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_VALID    = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ELEM_W-1:0] element;
    logic [TEAM_W-1:0] team;
  } tgq_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ELEM_W-1:0] value;
  } tgq_out_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_step;
    logic load;
    logic commit;
  } tgq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic slot_free;
  } tgq_sts_t;

endpackage

`default_nettype wire

>>> rtl/tgq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tgq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/tgq_ctrl.sv
// Sequencer of the grouped queue: clearing pass, accept, write-back.
// Depends on tgq_pkg.
`default_nettype none

module tgq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output tgq_pkg::tgq_cmd_t       cmd,
  input  wire tgq_pkg::tgq_sts_t  sts
);
  import tgq_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WB
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd.clear_step = (state_r == S_CLEAR);
    cmd.load       = (state_r == S_IDLE) && in_valid;
    cmd.commit     = (state_r == S_WB) && sts.slot_free;
    in_ready       = (state_r == S_IDLE);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        // hold until the result register can take the outcome
        if (sts.slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tgq_dpath.sv
// Datapath of the grouped queue: team map, node store, team lists,
// team-order ring and result register. Depends on tgq_pkg and tgq_ram.
`default_nettype none

module tgq_dpath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tgq_pkg::tgq_in_t   in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output tgq_pkg::tgq_out_t       out_data,
  input  wire tgq_pkg::tgq_cmd_t  cmd,
  output tgq_pkg::tgq_sts_t       sts
);
  import tgq_pkg::*;

  localparam int EIDX_W = $clog2(NUM_ELEMENTS);

  // Held item and small per-team state
  tgq_in_t           item_r;
  logic [NODE_W-1:0] team_first_r [NUM_TEAMS];
  logic [NODE_W-1:0] team_last_r  [NUM_TEAMS];
  logic [TEAM_W-1:0] ring_r       [NUM_TEAMS];
  logic [NUM_TEAMS-1:0] waiting_r;
  logic [TEAM_W-1:0] ord_rd_r, ord_wr_r;
  logic [NODE_W-1:0] free_head_r, free_head_nxt;
  logic [CNT_W-1:0]  unused_r, in_use_r;
  logic [EIDX_W-1:0] clr_cnt_r;
  logic              out_valid_r;
  tgq_out_t          out_r, result;

  // RAM ports
  logic              tm_we;
  logic [EIDX_W-1:0] tm_waddr;
  logic [TEAM_W-1:0] tm_wdata, tm_rdata;
  logic              lk_we;
  logic [NODE_W-1:0] lk_waddr, lk_wdata, lk_raddr, lk_rdata;
  logic              vl_we;
  logic [ELEM_W-1:0] vl_rdata;

  // Decode
  logic [TEAM_W-1:0] head_team, enq_team;
  logic [NODE_W-1:0] head_node, new_node;
  logic is_asg, is_enq, is_deq, full, empty, from_unused;
  logic enq_ok, deq_ok, deq_last, enq_join;

  assign head_team   = ring_r[ord_rd_r];
  assign head_node   = team_first_r[head_team];
  assign enq_team    = tm_rdata;
  assign is_asg      = (item_r.kind == KIND_ASSIGN);
  assign is_enq      = (item_r.kind == KIND_ENQUEUE);
  assign is_deq      = (item_r.kind == KIND_DEQUEUE);
  assign full        = (in_use_r == CNT_W'(CAPACITY));
  assign empty       = (in_use_r == '0);
  assign from_unused = (unused_r < CNT_W'(CAPACITY));
  assign new_node    = from_unused ? unused_r[NODE_W-1:0] : free_head_r;
  assign enq_ok      = is_enq && !full;
  assign deq_ok      = is_deq && !empty;
  assign deq_last    = (head_node == team_last_r[head_team]);
  assign enq_join    = waiting_r[enq_team];

  // Team map: clearing pass writes zero, assign writes the team
  assign tm_we    = cmd.clear_step || (cmd.commit && is_asg);
  assign tm_waddr = cmd.clear_step ? clr_cnt_r : item_r.element[EIDX_W-1:0];
  assign tm_wdata = cmd.clear_step ? '0 : item_r.team;

  // Link store: chain a joining enqueue, or push a freed node
  assign lk_we    = cmd.commit && ((enq_ok && enq_join) || deq_ok);
  assign lk_waddr = deq_ok ? head_node : team_last_r[enq_team];
  assign lk_wdata = deq_ok ? free_head_r : new_node;
  assign lk_raddr = (in_data.kind == KIND_DEQUEUE) ? head_node : free_head_r;

  assign vl_we = cmd.commit && enq_ok;

  tgq_ram #(.WIDTH(TEAM_W), .DEPTH(NUM_ELEMENTS)) u_team_map (
    .clk   (clk),
    .we    (tm_we),
    .waddr (tm_waddr),
    .wdata (tm_wdata),
    .re    (cmd.load),
    .raddr (in_data.element[EIDX_W-1:0]),
    .rdata (tm_rdata)
  );

  tgq_ram #(.WIDTH(NODE_W), .DEPTH(CAPACITY)) u_node_link (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .re    (cmd.load),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  tgq_ram #(.WIDTH(ELEM_W), .DEPTH(CAPACITY)) u_node_value (
    .clk   (clk),
    .we    (vl_we),
    .waddr (new_node),
    .wdata (item_r.element),
    .re    (cmd.load),
    .raddr (head_node),
    .rdata (vl_rdata)
  );

  always_comb begin
    result.status = ST_ACCEPTED;
    result.value  = '0;
    unique case (item_r.kind)
      KIND_ENQUEUE: begin
        result.status = full ? ST_FULL : ST_ACCEPTED;
      end
      KIND_DEQUEUE: begin
        if (empty) begin
          result.status = ST_EMPTY;
        end else begin
          result.status = ST_VALID;
          result.value  = vl_rdata;
        end
      end
      default: result.status = ST_ACCEPTED;
    endcase
  end

  always_comb begin
    free_head_nxt = free_head_r;
    if (enq_ok && !from_unused) begin
      free_head_nxt = lk_rdata;
    end else if (deq_ok) begin
      free_head_nxt = head_node;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r   <= '0;
      ord_rd_r    <= '0;
      ord_wr_r    <= '0;
      free_head_r <= '0;
      unused_r    <= '0;
      in_use_r    <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
        free_head_r <= free_head_nxt;
        if (enq_ok) begin
          in_use_r <= in_use_r + 1'b1;
          if (from_unused) begin
            unused_r <= unused_r + 1'b1;
          end
          if (!enq_join) begin
            waiting_r[enq_team] <= 1'b1;
            ord_wr_r            <= ord_wr_r + 1'b1;
          end
        end
        if (deq_ok) begin
          in_use_r <= in_use_r - 1'b1;
          if (deq_last) begin
            waiting_r[head_team] <= 1'b0;
            ord_rd_r             <= ord_rd_r + 1'b1;
          end
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.commit) begin
      out_r <= result;
      if (enq_ok) begin
        team_last_r[enq_team] <= new_node;
        if (!enq_join) begin
          team_first_r[enq_team] <= new_node;
          ring_r[ord_wr_r]       <= enq_team;
        end
      end
      if (deq_ok && !deq_last) begin
        team_first_r[head_team] <= lk_rdata;
      end
    end
  end

  assign sts.clear_last = &clr_cnt_r;
  assign sts.slot_free  = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_data       = out_r;

endmodule

`default_nettype wire

>>> rtl/team_grouped_queue.sv
// Grouped queue (team queue): elements of one team queue together.
// Instantiates tgq_ctrl and tgq_dpath; uses tgq_pkg and the assertion header.
//
// Usage:
//   in_*  : one transaction per operation: assign an element to a team,
//           enqueue an element, or dequeue the front element.
//   out_* : exactly one result transaction per input transaction, in order:
//           status (accepted, dequeued value valid, queue empty, store full
//           and element dropped) and the dequeued value, zero otherwise.
// Timing:
//   An operation is accepted in S_IDLE; its memory reads land in S_WB, where
//   its write-back commits once the result register can take it, so the block
//   takes no new transaction until the last is written back. The result is
//   registered and appears the cycle after write-back. The split comes from
//   the registered team map and node store RAM reads and the pointer write-back.
// Reset:
//   rst_n is synchronous. After reset the block sweeps the team map to team 0,
//   one entry a cycle over every entry, with in_ready low; then it runs.
// Stall:
//   A waiting result does not stop the next acceptance; only the write-back
//   holds while the result register is still full and out_ready is low.
`default_nettype none
`include "team_grouped_queue_defines.svh"

module team_grouped_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tgq_pkg::tgq_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tgq_pkg::tgq_out_t      out_data
);
  import tgq_pkg::*;

  tgq_cmd_t cmd;
  tgq_sts_t sts;

  // Sequencer: clearing pass, accept, write-back
  tgq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Storage, list pointers and result register
  tgq_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // One operation in flight: an acceptance closes the input until its write-back
  `TGQ_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second accept in a row")
  // Only a dequeue with data carries a value
  `TGQ_ASSERT_IMPLIES(a_value_zero, out_valid && (out_data.status != ST_VALID), out_data.value == '0, "value set without dequeue")
  // A write-back always lands in the result register
  `TGQ_ASSERT_NEXT(a_commit_shows, cmd.commit, out_valid, "write-back lost its result")

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the grouped (team) queue, team_grouped_queue.
// Depends on tgq_pkg for the transaction structs, the kind codes and the status codes.
// Runs directed rows, random operations, a pass with every team waiting, more random.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tgq_pkg::*;

  // The package has no name for the spare kind, so give it one here.
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam int CLK_HALF       = 2;
  localparam int RESET_CYCLES   = 6;
  // The sweep after reset holds in_ready low, and the receiver may also
  // stall. Give a wide margin.
  localparam int STALL_LIMIT    = 4000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_ITEMS   = 400;
  localparam int ELEM_POOL      = 64;

  // One row of the directed table. When has_result is set, the result
  // typed in the row is the one expected. Otherwise the predictor decides.
  typedef struct packed {
    logic [1:0]        kind;
    logic [ELEM_W-1:0] element;
    logic [TEAM_W-1:0] team;
    logic              has_result;
    logic [1:0]        status;
    logic [ELEM_W-1:0] value;
  } directed_row_t;

  localparam int NUM_ROWS = 22;

  logic     clk      = 1'b0;
  logic     rst_n    = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  tgq_in_t  in_data  = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  tgq_out_t out_data;

  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;

  // Expected results, oldest first.
  tgq_out_t pending_results[$];

  int error_count     = 0;
  int sent_count      = 0;
  int checked_count   = 0;
  int dequeued_count  = 0;
  int dropped_count   = 0;
  int empty_count     = 0;
  int quiet_cycles    = 0;

  // Shadow copy of the queue state.
  logic [TEAM_W-1:0] team_map  [NUM_ELEMENTS];
  logic [ELEM_W-1:0] node_val  [CAPACITY];
  logic [NODE_W-1:0] node_next [CAPACITY];
  logic [NODE_W-1:0] team_head [NUM_TEAMS];
  logic [NODE_W-1:0] team_tail [NUM_TEAMS];
  logic              team_busy [NUM_TEAMS];
  logic [TEAM_W-1:0] team_ring [NUM_TEAMS];
  logic [TEAM_W-1:0] ring_rd;
  logic [TEAM_W-1:0] ring_wr;
  logic [NODE_W-1:0] free_head;
  logic [CNT_W-1:0]  slots_used;
  logic [CNT_W-1:0]  occupancy;

  // Walk through empty dequeue, the spare kind, extreme fields, grouping
  // behind a waiting team member, and reassignment of a queued element.
  directed_row_t directed_rows [NUM_ROWS] = '{
    '{KIND_DEQUEUE, 10'd0,    5'd0,  1'b1, ST_EMPTY,    10'd0},
    '{KIND_SPARE,   10'd1023, 5'd31, 1'b1, ST_ACCEPTED, 10'd0},
    '{KIND_ASSIGN,  10'd1023, 5'd31, 1'b1, ST_ACCEPTED, 10'd0},
    '{KIND_ASSIGN,  10'd5,    5'd1,  1'b1, ST_ACCEPTED, 10'd0},
    '{KIND_ASSIGN,  10'd6,    5'd1,  1'b1, ST_ACCEPTED, 10'd0},
    '{KIND_ENQUEUE, 10'd0,    5'd0,  1'b1, ST_ACCEPTED, 10'd0},
    '{KIND_ENQUEUE, 10'd1023, 5'd0,  1'b1, ST_ACCEPTED, 10'd0},
    '{KIND_ENQUEUE, 10'd5,    5'd31, 1'b1, ST_ACCEPTED, 10'd0},
    '{KIND_ENQUEUE, 10'd1,    5'd0,  1'b0, ST_ACCEPTED, 10'd0},
    '{KIND_ENQUEUE, 10'd6,    5'd0,  1'b0, ST_ACCEPTED, 10'd0},
    '{KIND_ASSIGN,  10'd0,    5'd1,  1'b0, ST_ACCEPTED, 10'd0},
    '{KIND_ENQUEUE, 10'd0,    5'd0,  1'b0, ST_ACCEPTED, 10'd0},
    '{KIND_DEQUEUE, 10'd0,    5'd0,  1'b1, ST_VALID,    10'd0},
    '{KIND_DEQUEUE, 10'd0,    5'd0,  1'b0, ST_ACCEPTED, 10'd0},
    '{KIND_DEQUEUE, 10'd1023, 5'd31, 1'b0, ST_ACCEPTED, 10'd0},
    '{KIND_ENQUEUE, 10'd1023, 5'd0,  1'b0, ST_ACCEPTED, 10'd0},
    '{KIND_DEQUEUE, 10'd0,    5'd0,  1'b0, ST_ACCEPTED, 10'd0},
    '{KIND_DEQUEUE, 10'd0,    5'd0,  1'b0, ST_ACCEPTED, 10'd0},
    '{KIND_DEQUEUE, 10'd0,    5'd0,  1'b0, ST_ACCEPTED, 10'd0},
    '{KIND_DEQUEUE, 10'd0,    5'd0,  1'b1, ST_VALID,    10'd1023},
    '{KIND_DEQUEUE, 10'd0,    5'd0,  1'b1, ST_EMPTY,    10'd0},
    '{KIND_ASSIGN,  10'd1023, 5'd0,  1'b1, ST_ACCEPTED, 10'd0}
  };

  team_grouped_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #CLK_HALF clk = ~clk;

  // Clear the shadow state to the post-reset picture.
  task automatic clear_queue_model();
    for (int i = 0; i < NUM_ELEMENTS; i++) team_map[i] = '0;
    for (int i = 0; i < NUM_TEAMS; i++) team_busy[i] = 1'b0;
    ring_rd    = '0;
    ring_wr    = '0;
    free_head  = '0;
    slots_used = '0;
    occupancy  = '0;
  endtask

  // Apply one operation to the shadow queue and return the result it gives.
  function automatic tgq_out_t queue_model_step(tgq_in_t op);
    tgq_out_t          res;
    logic [TEAM_W-1:0] t;
    logic [NODE_W-1:0] n;
    res.status = ST_ACCEPTED;
    res.value  = '0;
    case (op.kind)
      KIND_ASSIGN: begin
        team_map[op.element] = op.team;
      end
      KIND_ENQUEUE: begin
        if (occupancy >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          t = team_map[op.element];
          // Hand out unused slots in order first, then take from the free list
          if (slots_used < CAPACITY) begin
            n = slots_used[NODE_W-1:0];
            slots_used++;
          end else begin
            n = free_head;
            free_head = node_next[n];
          end
          occupancy++;
          node_val[n] = op.element;
          if (team_busy[t]) begin
            node_next[team_tail[t]] = n;
            team_tail[t] = n;
          end else begin
            team_head[t] = n;
            team_tail[t] = n;
            team_busy[t] = 1'b1;
            team_ring[ring_wr] = t;
            ring_wr++;
          end
        end
      end
      KIND_DEQUEUE: begin
        if (occupancy == 0) begin
          res.status = ST_EMPTY;
        end else begin
          t = team_ring[ring_rd];
          n = team_head[t];
          res.status = ST_VALID;
          res.value  = node_val[n];
          if (n == team_tail[t]) begin
            team_busy[t] = 1'b0;
            ring_rd++;
          end else begin
            team_head[t] = node_next[n];
          end
          node_next[n] = free_head;
          free_head = n;
          occupancy--;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Present one transaction, idling first at the sender's rate, and hold it
  // until it is accepted. Then record what it should give back.
  task automatic send_op(tgq_in_t op, bit has_result, tgq_out_t typed_result);
    tgq_out_t predicted;
    tgq_out_t expected;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = queue_model_step(op);
    expected  = has_result ? typed_result : predicted;
    pending_results = {pending_results, expected};
    sent_count++;
  endtask

  task automatic send_plain(logic [1:0] kind, logic [ELEM_W-1:0] element,
                            logic [TEAM_W-1:0] team);
    tgq_in_t op;
    op.kind    = kind;
    op.element = element;
    op.team    = team;
    send_op(op, 1'b0, '0);
  endtask

  // Hold the input side low until every expected result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Random mix. Elements mostly come from a small pool so that team grouping
  // happens often. Sometimes they span the full range.
  task automatic send_random(int count);
    int                roll;
    int                deq_weight;
    logic [1:0]        kind;
    logic [ELEM_W-1:0] element;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      // Lean towards dequeues once the queue has grown, to keep it bounded
      deq_weight = (occupancy > 48) ? 50 : 30;
      if (roll < 20) kind = KIND_ASSIGN;
      else if (roll < 95 - deq_weight) kind = KIND_ENQUEUE;
      else if (roll < 95) kind = KIND_DEQUEUE;
      else kind = KIND_SPARE;
      if ($urandom_range(99) < 70) element = ELEM_W'($urandom_range(ELEM_POOL - 1));
      else element = ELEM_W'($urandom_range(NUM_ELEMENTS - 1));
      send_plain(kind, element, TEAM_W'($urandom_range(NUM_TEAMS - 1)));
    end
  endtask

  // Check results and drive the receiver's stalls. Sample out_ready before
  // it is redrawn for the next cycle.
  always @(posedge clk) begin : result_check
    tgq_out_t want;
    if (rst_n && out_valid && out_ready) begin
      checked_count++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: status %0d value %0d",
               out_data.status, out_data.value);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_data.status);
          error_count++;
        end
        if (out_data.value !== want.value) begin
          $error("value mismatch: expected %0d, got %0d", want.value, out_data.value);
          error_count++;
        end
        case (want.status)
          ST_VALID: dequeued_count++;
          ST_FULL:  dropped_count++;
          ST_EMPTY: empty_count++;
          default: ;
        endcase
      end
    end
    out_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Watchdog: count cycles with no transaction on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_results.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    tgq_in_t  op;
    tgq_out_t typed;
    clear_queue_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // First phase: the sender is mostly busy and the receiver mostly stalls
    sender_idle_pct   = 34;
    receiver_idle_pct = 81;
    foreach (directed_rows[i]) begin
      op.kind      = directed_rows[i].kind;
      op.element   = directed_rows[i].element;
      op.team      = directed_rows[i].team;
      typed.status = directed_rows[i].status;
      typed.value  = directed_rows[i].value;
      send_op(op, directed_rows[i].has_result, typed);
    end
    send_random(RANDOM_ITEMS / 3);

    // Second phase: the sender mostly idles and the receiver rarely stalls
    sender_idle_pct   = 81;
    receiver_idle_pct = 34;
    send_random(RANDOM_ITEMS / 3);

    // Hold off until the block has drained, empty the queue, then put one
    // element of every team in it so that the team ring is full, and empty
    // it again.
    wait_drained();
    while (occupancy != 0) send_plain(KIND_DEQUEUE, '0, '0);
    for (int t = 0; t < NUM_TEAMS; t++) begin
      send_plain(KIND_ASSIGN, ELEM_W'(t), TEAM_W'(t));
    end
    for (int t = 0; t < NUM_TEAMS; t++) begin
      send_plain(KIND_ENQUEUE, ELEM_W'(t), '0);
    end
    while (occupancy != 0) send_plain(KIND_DEQUEUE, '0, '0);
    send_plain(KIND_DEQUEUE, '0, '0);

    // Third phase: no idling on either side
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    send_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered: %0d transactions sent, %0d results checked", sent_count, checked_count);
    $display("covered: %0d dequeues with data, %0d empty dequeues, %0d drops on full store",
             dequeued_count, empty_count, dropped_count);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
